@@ sv/asf_pkg.sv @@
// shared constants, codes and types of the adts sync finder
package asf_pkg;

	localparam int BUF_DEPTH = 16384;
	localparam int AW        = $clog2(BUF_DEPTH);
	localparam int CNT_W     = AW + 1;
	localparam int FL_W      = 13;
	localparam int ADDR_W    = ((AW > FL_W) ? AW : FL_W) + 1;
	localparam int SUM_W     = ADDR_W + 1;
	localparam int OFF_W     = 14;

	localparam logic [7:0] SYNC_HI     = 8'hFF;
	localparam logic [3:0] SYNC_LO     = 4'hF;
	localparam logic [7:0] LAYER_MASK  = 8'h06;
	localparam logic [3:0] MAX_SR_IDX  = 4'd12;
	localparam int         MIN_HDR     = 7;
	localparam logic [2:0] HDR_BYTES   = 3'd4;

	typedef enum logic [1:0] {
		ST_FOUND    = 2'd0,
		ST_NO_SYNC  = 2'd1,
		ST_PAST_END = 2'd2,
		ST_BAD_HDR  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_LOAD,
		S_SCAN,
		S_HDR,
		S_CHK,
		S_SY0,
		S_SY1,
		S_DONE
	} fsm_t;

	typedef struct packed {
		logic          en;
		logic [AW-1:0] addr;
		logic [7:0]    data;
	} wr_req_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} rd_req_t;

endpackage

@@ sv/asf_buf.sv @@
// byte buffer: one write port, one registered read port, reads past the fill read as zero
module asf_buf import asf_pkg::*; (
	input  logic             clk,
	input  wr_req_t          wr,
	input  rd_req_t          rd,
	input  logic [CNT_W-1:0] fill,
	output logic [7:0]       rd_byte
);

	logic [7:0] mem [BUF_DEPTH];
	logic [7:0] rd_data_s1;
	logic       oob_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data_s1 <= mem[rd.addr[AW-1:0]];
			oob_s1     <= rd.addr >= ADDR_W'(fill);
		end
	end

	assign rd_byte = oob_s1 ? 8'h00 : rd_data_s1;

endmodule

@@ sv/adts_sync_finder.sv @@
// adts sync finder top level: byte loading, search sequencer and result register
//
// usage
// - slave channel: one stream byte per transfer, s_tlast flags the final byte of a
//   buffer; bytes are taken at one per cycle while loading
// - bytes beyond the buffer depth are dropped, the search still runs on what is held
// - the transfer carrying s_tlast closes the buffer and starts the search; s_tready
//   stays low until the search has finished and its result is in the output register
// - search cost: about one scanned byte position per cycle, set by the single read
//   port of the byte buffer, broken at every sync candidate passed over by the
//   header reads, the length check, the reads of the second sync and a refill of
//   the scan
// - master channel: one transfer per buffer with status and offset; offset is zero
//   unless status is found
// - the result waits in the output register while the master side stalls; loading
//   of the next buffer goes on meanwhile, and the next search holds its result with
//   s_tready low until the register frees
// - reset clears the fill count and the sequencer; buffer contents are not cleared
module adts_sync_finder import asf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [1:0] status, [15:2] offset
);

	fsm_t             state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_q;
	logic [CNT_W-1:0] scan_addr_s1;
	logic             scan_vld_s1;
	logic [7:0]       prev_q;
	logic [AW-1:0]    cand_q;
	logic [7:0]       b1_q;
	logic [31:0]      hdr_q;
	logic [2:0]       hcnt_q;
	logic [FL_W-1:0]  fl_q;
	logic             sync0_q;
	status_t          res_stat_q;
	logic             out_vld_q;
	status_t          out_stat_q;
	logic [OFF_W-1:0] out_off_q;

	wr_req_t          wr;
	rd_req_t          rd;
	logic [7:0]       rd_byte;
	logic             hit, past_end, sync2, hdr_good, out_free, fin;
	status_t          fin_stat;
	logic [FL_W-1:0]  fl_w;
	logic [SUM_W-1:0] end_sum;

	asf_buf u_buf (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.fill    (count_q),
		.rd_byte (rd_byte)
	);

	// byte at a candidate plus one arrives while the candidate byte is held in prev_q
	assign hit = scan_vld_s1 && (prev_q == SYNC_HI) && (rd_byte[7:4] == SYNC_LO);

	// header bytes two to five sit in hdr_q, oldest in the top byte
	assign fl_w     = {hdr_q[17:16], hdr_q[15:8], hdr_q[7:5]};
	assign end_sum  = SUM_W'(cand_q) + SUM_W'(fl_w) + SUM_W'(MIN_HDR);
	assign past_end = end_sum > SUM_W'(count_q);
	assign sync2    = sync0_q && (rd_byte[7:4] == SYNC_LO);
	assign hdr_good = ((b1_q & LAYER_MASK) == 8'h00) && (hdr_q[29:26] <= MAX_SR_IDX) &&
		(fl_q >= FL_W'(MIN_HDR));
	assign out_free = !out_vld_q || m_tready;

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		wr.en    = 1'b0;
		wr.addr  = count_q[AW-1:0];
		wr.data  = s_tdata;
		rd.en    = 1'b0;
		rd.addr  = ADDR_W'(scan_q);
		fin      = 1'b0;
		fin_stat = ST_NO_SYNC;
		case (state_q)
			S_LOAD: begin
				s_tready = 1'b1;
				wr.en    = s_tvalid && (count_q < CNT_W'(BUF_DEPTH));
				if (s_tvalid && s_tlast) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (hit) begin
					state_d = S_HDR;
				end else if (scan_q < count_q) begin
					rd.en = 1'b1;
				end else if (!scan_vld_s1) begin
					fin      = 1'b1;
					fin_stat = ST_NO_SYNC;
					state_d  = S_DONE;
				end
			end
			S_HDR: begin
				rd.addr = ADDR_W'(cand_q) + ADDR_W'(hcnt_q) + ADDR_W'(2);
				if (hcnt_q < HDR_BYTES) begin
					rd.en = 1'b1;
				end else begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				rd.addr = ADDR_W'(cand_q) + ADDR_W'(fl_w);
				if (past_end) begin
					fin      = 1'b1;
					fin_stat = ST_PAST_END;
					state_d  = S_DONE;
				end else begin
					rd.en   = 1'b1;
					state_d = S_SY0;
				end
			end
			S_SY0: begin
				rd.en   = 1'b1;
				rd.addr = ADDR_W'(cand_q) + ADDR_W'(fl_q) + ADDR_W'(1);
				state_d = S_SY1;
			end
			S_SY1: begin
				if (sync2) begin
					fin      = 1'b1;
					fin_stat = hdr_good ? ST_FOUND : ST_BAD_HDR;
					state_d  = S_DONE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			count_q     <= '0;
			scan_vld_s1 <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			scan_vld_s1 <= (state_q == S_SCAN) && rd.en;
			if (wr.en && s_tready) begin
				count_q <= count_q + CNT_W'(1);
			end else if ((state_q == S_DONE) && out_free) begin
				count_q <= '0;
			end
			if ((state_q == S_DONE) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// search datapath
	always_ff @(posedge clk) begin
		if ((state_q == S_SCAN) && rd.en) begin
			scan_addr_s1 <= scan_q;
		end
		if (fin) begin
			res_stat_q <= fin_stat;
		end
		case (state_q)
			S_LOAD: begin
				scan_q <= '0;
				prev_q <= 8'h00;
			end
			S_SCAN: begin
				if (hit) begin
					cand_q <= AW'(scan_addr_s1 - CNT_W'(1));
					b1_q   <= rd_byte;
					hcnt_q <= '0;
				end else begin
					if (scan_vld_s1) begin
						prev_q <= rd_byte;
					end
					if (rd.en) begin
						scan_q <= scan_q + CNT_W'(1);
					end
				end
			end
			S_HDR: begin
				hcnt_q <= hcnt_q + 3'd1;
				if (hcnt_q != 3'd0) begin
					hdr_q <= {hdr_q[23:0], rd_byte};
				end
			end
			S_CHK: begin
				fl_q <= fl_w;
			end
			S_SY0: begin
				sync0_q <= rd_byte == SYNC_HI;
			end
			S_SY1: begin
				// no second sync: resume one past the candidate
				if (!sync2) begin
					prev_q <= b1_q;
					scan_q <= CNT_W'(cand_q) + CNT_W'(2);
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_stat_q <= res_stat_q;
					out_off_q  <= (res_stat_q == ST_FOUND) ? OFF_W'(cand_q) : '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_off_q, out_stat_q};

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(BUF_DEPTH))
		else $error("fill count beyond buffer depth");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (scan_q <= count_q))
		else $error("scan position beyond fill count");

	a_second_sync_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SY0) |-> (rd.addr < ADDR_W'(count_q)))
		else $error("second sync read outside loaded bytes");

	a_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[1:0] != ST_FOUND)) |-> (m_tdata[15:2] == '0))
		else $error("offset set on a result that is not found");
`endif

endmodule

@@ test/adts_sync_finder_test.sv @@
// testbench for the adts sync finder: byte buffers in, search results checked against a predictor
module adts_sync_finder_test;
	import asf_pkg::*;

	localparam int CYCLE          = 8;
	localparam int RESET_CYCLES   = 11;
	localparam int RANDOM_BYTES   = 1060;
	localparam int QUIET_TAIL     = 150;    // bytes at the end sent with no idling at all
	localparam int LONG_HOLD      = 400;    // cycles the result side holds off once
	localparam int SETTLE_CYCLES  = 64;
	localparam int TIMEOUT_CYCLES = 400000;

	// one search outcome as carried by a master transfer
	typedef struct packed {
		status_t          status;
		logic [OFF_W-1:0] offset;
	} search_result_t;

	// shapes of generated buffers
	typedef enum int {
		MIX_NOISE,
		MIX_GOOD,
		MIX_BAD_LAYER,
		MIX_BAD_RATE,
		MIX_SHORT_LEN,
		MIX_TRUNC,
		MIX_SKIP
	} frame_mix_t;

	// keeps its own copy of the byte buffer, predicts each search and
	// checks the results in order
	class sync_search_board;
		logic [7:0]     mem [BUF_DEPTH];
		int unsigned    fill;
		search_result_t expected_results[$];
		int unsigned    errors;
		int unsigned    bytes_seen;
		int unsigned    dropped;
		int unsigned    tally[4];

		function new();
			fill = 0;
			errors = 0;
			bytes_seen = 0;
			dropped = 0;
			foreach (tally[k])
				tally[k] = 0;
		endfunction

		// positions past the loaded bytes read as zero
		function logic [7:0] peek(int unsigned idx);
			return (idx < fill) ? mem[idx] : 8'h00;
		endfunction

		function bit sync_at(int unsigned idx);
			logic [7:0] hi, lo;
			hi = peek(idx);
			lo = peek(idx + 1);
			return hi == SYNC_HI && lo[7:4] == SYNC_LO;
		endfunction

		function int unsigned frame_bytes(int unsigned idx);
			logic [7:0] b3, b4, b5;
			b3 = peek(idx + 3);
			b4 = peek(idx + 4);
			b5 = peek(idx + 5);
			return {b3[1:0], b4, b5[7:5]};
		endfunction

		// first candidate with a frame running past the end, or with a
		// confirmed second sync, decides the outcome
		function search_result_t predict_search();
			search_result_t r;
			int unsigned    fl;
			logic [7:0]     b1, b2;
			r.status = ST_NO_SYNC;
			r.offset = '0;
			for (int unsigned i = 0; i + 1 < fill; i++) begin
				if (sync_at(i)) begin
					fl = frame_bytes(i);
					if (i + fl + MIN_HDR > fill) begin
						r.status = ST_PAST_END;
						return r;
					end
					if (sync_at(i + fl)) begin
						b1 = peek(i + 1);
						b2 = peek(i + 2);
						if ((b1 & LAYER_MASK) != 8'h00 || b2[5:2] > MAX_SR_IDX || fl < MIN_HDR)
							r.status = ST_BAD_HDR;
						else begin
							r.status = ST_FOUND;
							r.offset = i[OFF_W-1:0];
						end
						return r;
					end
				end
			end
			return r;
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			search_result_t r;
			bytes_seen++;
			if (fill < BUF_DEPTH) begin
				mem[fill] = b;
				fill++;
			end else
				dropped++;
			if (last) begin
				r = predict_search();
				expected_results.push_back(r);
				tally[r.status]++;
				fill = 0;
			end
		endfunction

		function void check_result(logic [15:0] word);
			search_result_t   want;
			logic [1:0]       got_status;
			logic [OFF_W-1:0] got_offset;
			got_status = word[1:0];
			got_offset = word[15:2];
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, actual status %0d offset %0d",
					$time, got_status, got_offset);
				return;
			end
			want = expected_results.pop_front();
			if (got_status !== want.status) begin
				errors++;
				$display("%0t: status mismatch, expected %0d actual %0d",
					$time, want.status, got_status);
			end
			if (got_offset !== want.offset) begin
				errors++;
				$display("%0t: offset mismatch, expected %0d actual %0d",
					$time, want.offset, got_offset);
			end
		endfunction

		function int unsigned outstanding();
			return expected_results.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;     // [7:0] data_byte
	logic        s_tlast;     // last_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;     // [1:0] status, [15:2] offset

	sync_search_board board = new();

	// idling rates in percent, changed by the stimulus as the run goes on
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit hold_req    = 1'b0;

	always begin
		#(CYCLE / 2) clk = 1'b1;
		#(CYCLE / 2) clk = 1'b0;
	end

	adts_sync_finder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// ---------------------------------------------------------------- buffer building

	function automatic void add_noise(ref logic [7:0] q[$], input int unsigned n);
		// never 0xff, so filler cannot start a sync of its own
		repeat (n)
			q.push_back(8'($urandom_range(0, 254)));
	endfunction

	// seven header bytes with the given frame length, layer and sampling index,
	// every other field random
	function automatic void add_header(ref logic [7:0] q[$], input int unsigned len,
			input logic [1:0] layer, input logic [3:0] rate);
		logic [12:0] fl;
		logic [7:0]  r;
		fl = len[12:0];
		r  = 8'($urandom);
		q.push_back(SYNC_HI);
		q.push_back({SYNC_LO, r[0], layer, r[1]});
		q.push_back({r[3:2], rate, r[5:4]});
		r = 8'($urandom);
		q.push_back({r[5:0], fl[12:11]});
		q.push_back(fl[10:3]);
		q.push_back({fl[2:0], r[4:0]});
		q.push_back(8'($urandom));
	endfunction

	function automatic int unsigned pick_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(21, 120) : $urandom_range(7, 20);
	endfunction

	function automatic logic [3:0] good_rate();
		return 4'($urandom_range(0, 12));
	endfunction

	// a frame followed by the next sync, the first header shaped by the caller
	function automatic void add_pair(ref logic [7:0] q[$], input logic [1:0] layer,
			input logic [3:0] rate);
		int unsigned len;
		len = pick_len();
		add_header(q, len, layer, rate);
		add_noise(q, len - 7);
		add_header(q, $urandom_range(7, 2000), 2'b00, good_rate());
	endfunction

	function automatic void make_buffer(ref logic [7:0] q[$]);
		int unsigned lead, len, cut, pick;
		frame_mix_t  mix;
		q.delete();
		lead = $urandom_range(0, 8);
		pick = $urandom_range(0, 99);
		if (pick < 40)      mix = MIX_GOOD;
		else if (pick < 50) mix = MIX_NOISE;
		else if (pick < 58) mix = MIX_BAD_LAYER;
		else if (pick < 66) mix = MIX_BAD_RATE;
		else if (pick < 74) mix = MIX_SHORT_LEN;
		else if (pick < 86) mix = MIX_TRUNC;
		else                mix = MIX_SKIP;
		case (mix)
			MIX_NOISE: begin
				repeat ($urandom_range(1, 40))
					q.push_back(8'($urandom));
			end
			MIX_GOOD: begin
				add_noise(q, lead);
				add_pair(q, 2'b00, good_rate());
				add_noise(q, $urandom_range(0, 4));
			end
			MIX_BAD_LAYER: begin
				add_noise(q, lead);
				add_pair(q, 2'($urandom_range(1, 3)), good_rate());
				add_noise(q, $urandom_range(0, 4));
			end
			MIX_BAD_RATE: begin
				add_noise(q, lead);
				add_pair(q, 2'b00, 4'($urandom_range(13, 15)));
				add_noise(q, $urandom_range(0, 4));
			end
			MIX_SHORT_LEN: begin
				// length under the header size; a sync is planted where the
				// length points, even inside the header
				add_noise(q, lead);
				len = $urandom_range(0, 6);
				add_header(q, len, 2'b00, good_rate());
				add_noise(q, len + $urandom_range(0, 3));
				if (len != 0) begin
					q[lead + len]     = SYNC_HI;
					q[lead + len + 1] = {SYNC_LO, 4'($urandom)};
				end
			end
			MIX_TRUNC: begin
				// buffer ends before frame plus header, at times inside the header
				add_noise(q, lead);
				len = $urandom_range(0, 8191);
				add_header(q, len, 2'b00, good_rate());
				add_noise(q, 40);
				cut = lead + $urandom_range(2, (len + 6 < 40) ? len + 6 : 40);
				while (q.size() > cut)
					void'(q.pop_back());
			end
			default: begin
				// first candidate lacks its second sync and is passed over
				add_noise(q, lead);
				len = $urandom_range(7, 20);
				add_header(q, len, 2'b00, good_rate());
				add_noise(q, len - 7);
				q.push_back(8'h00);
				add_pair(q, 2'b00, good_rate());
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- driving

	// one byte transfer; valid stays up afterwards until the next change
	task automatic push_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do
			@(posedge clk);
		while (!s_tready);
		board.note_byte(b, last);
	endtask

	task automatic tx_gap(input int unsigned n);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (n - 1)
			@(negedge clk);
	endtask

	task automatic tx_stop();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic send_buffer(ref logic [7:0] q[$]);
		for (int k = 0; k < q.size(); k++) begin
			if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
				tx_gap($urandom_range(1, 3));
			push_byte(q[k], k == q.size() - 1);
		end
	endtask

	task automatic wait_drained();
		while (board.outstanding() != 0)
			@(posedge clk);
	endtask

	// result side: short random stalls, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD)
					@(negedge clk);
				hold_req = 1'b0;
				m_tready <= 1'b1;
			end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3))
					@(negedge clk);
				m_tready <= 1'b1;
			end else
				m_tready <= 1'b1;
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata);

	// ---------------------------------------------------------------- stimulus

	initial begin
		logic [7:0]  stim[$];
		int unsigned random_bytes;
		int unsigned buffers;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		s_tlast  = 1'b0;
		repeat (RESET_CYCLES)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed buffers
		tx_idle_pct = 20;
		rx_idle_pct = 20;
		stim = '{8'h00};                     // single byte, nothing to scan
		send_buffer(stim);
		stim = '{8'hFF};                     // lone sync byte
		send_buffer(stim);
		stim = '{8'hFF, 8'hF0};              // sync with no room for a frame
		send_buffer(stim);
		stim = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};   // all ones, longest length
		send_buffer(stim);
		stim.delete();                       // zero length points back at itself
		add_header(stim, 0, 2'b00, 4'd3);
		add_noise(stim, 1);
		send_buffer(stim);
		stim.delete();                       // smallest frame at offset zero
		add_header(stim, 7, 2'b00, 4'd0);
		add_header(stim, 7, 2'b00, 4'd0);
		send_buffer(stim);
		stim.delete();                       // highest valid sampling index
		add_noise(stim, 1);
		add_header(stim, 7, 2'b00, 4'd12);
		add_header(stim, 7, 2'b00, 4'd5);
		send_buffer(stim);
		stim.delete();                       // layer bits set
		add_header(stim, 7, 2'b11, 4'd0);
		add_header(stim, 7, 2'b00, 4'd0);
		send_buffer(stim);
		stim.delete();                       // sampling index out of range
		add_header(stim, 7, 2'b00, 4'd15);
		add_header(stim, 7, 2'b00, 4'd0);
		send_buffer(stim);
		stim.delete();                       // one byte short of the second header
		add_header(stim, 7, 2'b00, 4'd1);
		add_header(stim, 7, 2'b00, 4'd1);
		void'(stim.pop_back());
		send_buffer(stim);

		// random buffers of mixed shapes, well-formed frames with random content the most common
		random_bytes = 0;
		buffers = 0;
		while (random_bytes < RANDOM_BYTES) begin
			if (random_bytes + QUIET_TAIL >= RANDOM_BYTES) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else if ($urandom_range(0, 3) == 0) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else begin
				tx_idle_pct = $urandom_range(10, 40);
				rx_idle_pct = $urandom_range(10, 40);
			end
			// result side goes quiet while buffers keep coming, so the
			// output register fills and the next search has to wait
			if (buffers == 6)
				hold_req = 1'b1;
			// sender stops until every outstanding result is in
			if (buffers == 20) begin
				tx_stop();
				wait_drained();
			end
			make_buffer(stim);
			send_buffer(stim);
			random_bytes += stim.size();
			buffers++;
		end

		tx_stop();
		wait_drained();
		repeat (SETTLE_CYCLES)
			@(posedge clk);

		$display("covered %0d bytes in %0d buffers, %0d bytes dropped beyond the buffer depth",
			board.bytes_seen, buffers + 10, board.dropped);
		$display("outcomes: found %0d, no sync %0d, past end %0d, bad header %0d",
			board.tally[ST_FOUND], board.tally[ST_NO_SYNC],
			board.tally[ST_PAST_END], board.tally[ST_BAD_HDR]);
		if (board.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// watchdog
	initial begin
		#(CYCLE * TIMEOUT_CYCLES);
		$display("timeout with %0d results outstanding", board.outstanding());
		$display("FAILURE");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/asf_pkg.sv
sv/asf_buf.sv
sv/adts_sync_finder.sv
test/adts_sync_finder_test.sv
